>>> rtl/core/npp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and tables for the NMEA position parser.
package npp_pkg;

	localparam int LAT_W   = 31;
	localparam int LON_W   = 32;
	localparam int CHAR_W  = 8;
	localparam int WHOLE_W = 20;
	localparam int DIG_W   = 3;
	localparam int LEN_W   = 4;
	localparam int FLD_W   = 3;
	localparam int PFX_W   = 3;
	localparam int PH_W    = 2;
	localparam int DEG_W   = 14;
	localparam int P10_W   = 24;
	localparam int M60_W   = 30;
	localparam int X15_W   = M60_W - 2;
	localparam int Q_W     = 25;
	localparam int DEGS_W  = 38;

	localparam logic [WHOLE_W-1:0] WHOLE_MAX = '1;
	localparam int unsigned LAT_LIMIT = 900000000;
	localparam int unsigned LON_LIMIT = 1800000000;
	localparam int unsigned DEG_SCALE = 10000000;

	// floor(x/25) for x < 2^18 is (x*RECIP25) >> 23
	localparam logic [18:0] RECIP25   = 19'd335545;
	localparam int          RECIP25_SH = 23;
	// floor(x/15) for x < 2^28 is (x*RECIP15) >> 32
	localparam logic [28:0] RECIP15   = 29'd286331154;
	localparam int          RECIP15_SH = 32;

	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
	localparam logic [CHAR_W-1:0] CH_W     = 8'h57;

	localparam logic [PFX_W-1:0] PFX_LEN = 3'd6;
	localparam logic [FLD_W-1:0] FLD_MAX = 3'd7;
	localparam logic [FLD_W-1:0] LAT_FLD_GGA = 3'd2;
	localparam logic [FLD_W-1:0] LAT_FLD_RMC = 3'd3;

	localparam logic [PH_W-1:0] PH_WHOLE = 2'd0;
	localparam logic [PH_W-1:0] PH_FRAC  = 2'd1;
	localparam logic [PH_W-1:0] PH_STOP  = 2'd2;

	localparam logic KIND_GGA = 1'b0;
	localparam logic KIND_RMC = 1'b1;

	function automatic logic [CHAR_W-1:0] pfx_char(input logic kind,
		input logic [PFX_W-1:0] pos);
		logic [CHAR_W-1:0] r;
		unique case (pos)
			3'd0: r = 8'h24;
			3'd1: r = 8'h47;
			3'd2: r = 8'h50;
			3'd3: r = (kind == KIND_RMC) ? 8'h52 : 8'h47;
			3'd4: r = (kind == KIND_RMC) ? 8'h4D : 8'h47;
			3'd5: r = (kind == KIND_RMC) ? 8'h43 : 8'h41;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [P10_W-1:0] pow10(input logic [DIG_W-1:0] n);
		logic [P10_W-1:0] r;
		unique case (n)
			3'd0: r = 24'd1;
			3'd1: r = 24'd10;
			3'd2: r = 24'd100;
			3'd3: r = 24'd1000;
			3'd4: r = 24'd10000;
			3'd5: r = 24'd100000;
			3'd6: r = 24'd1000000;
			3'd7: r = 24'd10000000;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/npp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for characters in and position fixes out.
interface npp_char_if;
	logic                      valid;
	logic                      ready;
	logic [npp_pkg::CHAR_W-1:0] char_in;
	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

interface npp_pos_if;
	logic                            valid;
	logic                            ready;
	logic signed [npp_pkg::LAT_W-1:0] latitude;
	logic signed [npp_pkg::LON_W-1:0] longitude;
	logic                            sentence_kind;
	modport source (output valid, output latitude, output longitude, output sentence_kind,
		input ready);
	modport sink (input valid, input latitude, input longitude, input sentence_kind,
		output ready);
endinterface

>>> rtl/core/npp_front.sv
`timescale 1ns / 1ps
// Front end: per-character sentence parser that emits one line record per valid line.
module npp_front #(
	parameter int FRACTION_DIGITS = 5,
	parameter int LAT_MAX_CHARS   = 10,
	parameter int LON_MAX_CHARS   = 11,
	parameter int FRAC_W          = 17,
	parameter int REC_W           = 83
) (
	input  logic             clk,
	input  logic             arst_n,
	npp_char_if.sink         chars,
	input  logic             full,
	output logic             push,
	output logic [REC_W-1:0] rec
);
	import npp_pkg::*;

	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [DIG_W-1:0]   fdig;
		logic [PH_W-1:0]    phase;
		logic [LEN_W-1:0]   len;
		logic               neg;
	} coord_t;

	function automatic coord_t feed(input coord_t c, input logic [CHAR_W-1:0] ch);
		coord_t              r;
		logic                is_dig;
		logic [WHOLE_W+3:0]  v;
		logic [FRAC_W+3:0]   f;
		r = c;
		is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
		v = {4'b0, c.whole} * (WHOLE_W+4)'(10) + (WHOLE_W+4)'(ch[3:0]);
		f = {4'b0, c.frac} * (FRAC_W+4)'(10) + (FRAC_W+4)'(ch[3:0]);
		unique case (c.phase)
			PH_WHOLE: begin
				if (is_dig) begin
					r.whole = (v > (WHOLE_W+4)'(WHOLE_MAX)) ? WHOLE_MAX : v[WHOLE_W-1:0];
				end else if (ch == CH_DOT) begin
					r.phase = PH_FRAC;
				end else begin
					r.phase = PH_STOP;
				end
			end
			PH_FRAC: begin
				if (is_dig) begin
					if (c.fdig < DIG_W'(FRACTION_DIGITS)) begin
						r.frac = f[FRAC_W-1:0];
						r.fdig = c.fdig + 1'b1;
					end
				end else begin
					r.phase = PH_STOP;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	logic [PFX_W-1:0] pfx_q, pfx_nxt;
	logic             gga_q, gga_nxt, rmc_q, rmc_nxt;
	logic [FLD_W-1:0] fld_q, fld_nxt, base;
	coord_t           lat_q, lat_nxt, lon_q, lon_nxt;
	logic [CHAR_W-1:0] ch;
	logic             acc, line_ok;

	assign ch    = chars.char_in;
	assign chars.ready = !full;
	assign acc   = chars.valid && !full;

	assign line_ok = (pfx_q == PFX_LEN) && (gga_q || rmc_q) &&
		(lat_q.len != '0) && (lon_q.len != '0);
	assign push = acc && (ch == CH_LF) && line_ok;
	assign rec  = {rmc_q, lon_q.neg, lon_q.fdig, lon_q.frac, lon_q.whole,
		lat_q.neg, lat_q.fdig, lat_q.frac, lat_q.whole};

	always_comb begin
		pfx_nxt = pfx_q;
		gga_nxt = gga_q;
		rmc_nxt = rmc_q;
		fld_nxt = fld_q;
		lat_nxt = lat_q;
		lon_nxt = lon_q;
		if (pfx_q < PFX_LEN) begin
			if (ch != pfx_char(KIND_GGA, pfx_q)) gga_nxt = 1'b0;
			if (ch != pfx_char(KIND_RMC, pfx_q)) rmc_nxt = 1'b0;
			pfx_nxt = pfx_q + 1'b1;
		end
		base = rmc_nxt ? LAT_FLD_RMC : LAT_FLD_GGA;
		if (ch == CH_COMMA) begin
			if (fld_q != FLD_MAX) fld_nxt = fld_q + 1'b1;
		end else if (fld_q == base) begin
			if (lat_q.len < LEN_W'(LAT_MAX_CHARS)) begin
				lat_nxt = feed(lat_q, ch);
				lat_nxt.len = lat_q.len + 1'b1;
			end
		end else if (fld_q == base + 3'd1) begin
			lat_nxt.neg = (ch == CH_S);
		end else if (fld_q == base + 3'd2) begin
			if (lon_q.len < LEN_W'(LON_MAX_CHARS)) begin
				lon_nxt = feed(lon_q, ch);
				lon_nxt.len = lon_q.len + 1'b1;
			end
		end else if (fld_q == base + 3'd3) begin
			lon_nxt.neg = (ch == CH_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q <= '0;
			gga_q <= 1'b1;
			rmc_q <= 1'b1;
			fld_q <= '0;
			lat_q <= '0;
			lon_q <= '0;
		end else if (acc && (ch != CH_CR)) begin
			if (ch == CH_LF) begin
				pfx_q <= '0;
				gga_q <= 1'b1;
				rmc_q <= 1'b1;
				fld_q <= '0;
				lat_q <= '0;
				lon_q <= '0;
			end else begin
				pfx_q <= pfx_nxt;
				gga_q <= gga_nxt;
				rmc_q <= rmc_nxt;
				fld_q <= fld_nxt;
				lat_q <= lat_nxt;
				lon_q <= lon_nxt;
			end
		end
	end

endmodule

>>> rtl/core/npp_fifo.sv
`timescale 1ns / 1ps
// Small line-record queue between the parser and the converter.
module npp_fifo #(
	parameter int WIDTH = 83,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> rtl/core/npp_conv.sv
`timescale 1ns / 1ps
// Four-stage ddmm.mmmm to 1e-7 degree converter for one coordinate.
module npp_conv #(
	parameter int          FRACTION_DIGITS = 5,
	parameter int          FRAC_W          = 17,
	parameter int          OUT_W           = 31,
	parameter int unsigned LIMIT           = 900000000
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [npp_pkg::WHOLE_W-1:0]  whole,
	input  logic [FRAC_W-1:0]            frac,
	input  logic [npp_pkg::DIG_W-1:0]    fdig,
	input  logic                         neg,
	output logic signed [OUT_W-1:0]      mag
);
	import npp_pkg::*;

	localparam int PSCALE = 10 ** FRACTION_DIGITS;
	localparam int SCALE  = 10 ** (7 - FRACTION_DIGITS);
	localparam int MINS_W = $clog2(100 * PSCALE);

	logic [WHOLE_W+18:0]     deg_prod;
	logic [FRAC_W+P10_W-1:0] sfrac_prod;
	logic [DEG_W-1:0]        deg_s1, deg_s2;
	logic [WHOLE_W-1:0]      whole_s1;
	logic [FRAC_W-1:0]       sfrac_s1;
	logic                    neg_s1, neg_s2, neg_s3;

	logic [WHOLE_W-1:0]      rem_full;
	logic [MINS_W-1:0]       mins;
	logic [M60_W-1:0]        m60;
	logic [X15_W-1:0]        x_s2;

	logic [X15_W+28:0]       q_prod;
	logic [Q_W-1:0]          q_s3;
	logic [DEGS_W-1:0]       degs_s3;

	logic [DEGS_W-1:0]       sum;
	logic [OUT_W-1:0]        mag_c;

	// whole / 100 as (whole / 4) / 25
	assign deg_prod   = (WHOLE_W+19)'(whole[WHOLE_W-1:2]) * (WHOLE_W+19)'(RECIP25);
	assign sfrac_prod = (FRAC_W+P10_W)'(frac) *
		(FRAC_W+P10_W)'(pow10(DIG_W'(FRACTION_DIGITS) - fdig));

	assign rem_full = whole_s1 - WHOLE_W'(deg_s1) * WHOLE_W'(100);
	assign mins     = MINS_W'(rem_full[6:0]) * MINS_W'(PSCALE) + MINS_W'(sfrac_s1);
	assign m60      = M60_W'(mins) * M60_W'(SCALE);

	// minutes / 60 as (m / 4) / 15
	assign q_prod = (X15_W+29)'(x_s2) * (X15_W+29)'(RECIP15);

	assign sum   = degs_s3 + DEGS_W'(q_s3);
	assign mag_c = (sum > DEGS_W'(LIMIT)) ? OUT_W'(LIMIT) : sum[OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1   <= deg_prod[RECIP25_SH +: DEG_W];
			whole_s1 <= whole;
			sfrac_s1 <= sfrac_prod[FRAC_W-1:0];
			neg_s1   <= neg;

			x_s2     <= m60[M60_W-1:2];
			deg_s2   <= deg_s1;
			neg_s2   <= neg_s1;

			q_s3     <= q_prod[RECIP15_SH +: Q_W];
			degs_s3  <= DEGS_W'(deg_s2) * DEGS_W'(DEG_SCALE);
			neg_s3   <= neg_s2;

			mag      <= neg_s3 ? -mag_c : mag_c;
		end
	end

endmodule

>>> rtl/core/nmea_position_parser_core.sv
`timescale 1ns / 1ps
// Top level of the NMEA GGA/RMC position parser: parser, record queue, converters.
//
//  channel  dir  modport          payload
//  chars    in   npp_char_if.sink char_in[7:0]
//  fixes    out  npp_pos_if.source latitude[30:0], longitude[31:0], sentence_kind
//
// One character per cycle; chars.ready drops only while the record queue is full.
// At the earliest, a fix follows the newline beat through the queue pop and the
// four converter stages, the last being the output register.
// Output stalls freeze the whole converter pipe; the queue absorbs QUEUE_DEPTH lines.
// Reset returns the parser to the start of a line and empties queue and pipe.
module nmea_position_parser_core #(
	parameter int FRACTION_DIGITS = 5,
	parameter int LAT_MAX_CHARS   = 10,
	parameter int LON_MAX_CHARS   = 11,
	parameter int QUEUE_DEPTH     = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	npp_char_if.sink   chars,
	npp_pos_if.source  fixes
);
	import npp_pkg::*;

	localparam int FRAC_W  = $clog2(10 ** FRACTION_DIGITS);
	localparam int COORD_W = WHOLE_W + FRAC_W + DIG_W + 1;
	localparam int REC_W   = 2 * COORD_W + 1;
	localparam int FRAC_LO = WHOLE_W;
	localparam int DIG_LO  = WHOLE_W + FRAC_W;
	localparam int NEG_B   = WHOLE_W + FRAC_W + DIG_W;

	logic             push, pop, full, empty, adv;
	logic [REC_W-1:0] rec_in, rec_out;
	logic [COORD_W-1:0] lat_rec, lon_rec;
	logic             v_s1, v_s2, v_s3, out_v_q;
	logic             kind_s1, kind_s2, kind_s3, kind_s4;

	npp_front #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.LAT_MAX_CHARS   (LAT_MAX_CHARS),
		.LON_MAX_CHARS   (LON_MAX_CHARS),
		.FRAC_W          (FRAC_W),
		.REC_W           (REC_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.full   (full),
		.push   (push),
		.rec    (rec_in)
	);

	npp_fifo #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (rec_in),
		.pop    (pop),
		.rdata  (rec_out),
		.full   (full),
		.empty  (empty)
	);

	assign adv = !out_v_q || fixes.ready;
	assign pop = adv && !empty;

	assign lat_rec = rec_out[COORD_W-1:0];
	assign lon_rec = rec_out[2*COORD_W-1:COORD_W];

	npp_conv #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.FRAC_W          (FRAC_W),
		.OUT_W           (LAT_W),
		.LIMIT           (LAT_LIMIT)
	) u_lat (
		.clk   (clk),
		.en    (adv),
		.whole (lat_rec[WHOLE_W-1:0]),
		.frac  (lat_rec[FRAC_LO +: FRAC_W]),
		.fdig  (lat_rec[DIG_LO +: DIG_W]),
		.neg   (lat_rec[NEG_B]),
		.mag   (fixes.latitude)
	);

	npp_conv #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.FRAC_W          (FRAC_W),
		.OUT_W           (LON_W),
		.LIMIT           (LON_LIMIT)
	) u_lon (
		.clk   (clk),
		.en    (adv),
		.whole (lon_rec[WHOLE_W-1:0]),
		.frac  (lon_rec[FRAC_LO +: FRAC_W]),
		.fdig  (lon_rec[DIG_LO +: DIG_W]),
		.neg   (lon_rec[NEG_B]),
		.mag   (fixes.longitude)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= rec_out[REC_W-1];
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
		end
	end

	assign fixes.valid         = out_v_q;
	assign fixes.sentence_kind = kind_s4;

endmodule

>>> test/nmea_position_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nmea_position_parser_core: directed and random NMEA lines.
module nmea_position_parser_core_tb;
	import npp_pkg::*;

	localparam int FRAC_KEEP    = 5;
	localparam int LAT_MAX_LEN  = 10;
	localparam int LON_MAX_LEN  = 11;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int MIN_PER_DEG  = 60;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic [16:0]        frac;
		logic [DIG_W-1:0]   ndig;
		logic [PH_W-1:0]    phase;
		logic [LEN_W-1:0]   len;
		logic [CHAR_W-1:0]  hemi;
	} coord_t;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
		logic                    kind;
	} fix_t;

	typedef enum logic [1:0] {ROW_MODEL, ROW_FIX, ROW_NONE} row_mode_t;

	typedef struct {
		string     text;
		bit        cr;
		row_mode_t mode;
		int        lat;
		int        lon;
		logic      kind;
	} dir_row_t;

	dir_row_t dir_rows [21] = '{
		'{"$GPGGA,,0000,N,00000,E", 0, ROW_FIX, 0, 0, KIND_GGA},
		'{"$GPGGA,,9000,S,18000,W", 0, ROW_FIX, -900000000, -1800000000, KIND_GGA},
		'{"$GPGGA,,9999999999,S,99999999999,W", 0, ROW_FIX, -900000000, -1800000000, KIND_GGA},
		'{"$GPRMC,,A,4530,N,09030,E", 0, ROW_FIX, 455000000, 905000000, KIND_RMC},
		'{"$GPRMC,,A,0200,S,00300,W,1,2,3,4,5,6", 0, ROW_FIX, -20000000, -30000000, KIND_RMC},
		'{"$GPGGA,,0100,NS,00100,WE", 1, ROW_FIX, -10000000, 10000000, KIND_GGA},
		'{"$GPGGA,,0100,x,00100,s", 0, ROW_FIX, 10000000, 10000000, KIND_GGA},
		'{"$GPGGA,,abc,N,-5,E", 0, ROW_FIX, 0, 0, KIND_GGA},
		'{"$GPGGA,,3000,N,,E", 0, ROW_NONE, 0, 0, KIND_GGA},
		'{"$GPGG", 0, ROW_NONE, 0, 0, KIND_GGA},
		'{"$GPXYZ,,1,N,1,E", 0, ROW_NONE, 0, 0, KIND_GGA},
		'{"", 0, ROW_NONE, 0, 0, KIND_GGA},
		'{"$GP,GGA,,1,N,1,E", 0, ROW_NONE, 0, 0, KIND_GGA},
		'{"$GPGGA", 0, ROW_NONE, 0, 0, KIND_GGA},
		'{"$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9", 0, ROW_MODEL, 0, 0, KIND_GGA},
		'{"$GPRMC,123519,A,4807.038,S,01131.000,W,022.4", 1, ROW_MODEL, 0, 0, KIND_RMC},
		'{"$GPGGA,,0100.000009,N,00100.99999,E", 0, ROW_MODEL, 0, 0, KIND_GGA},
		'{"$GPGGA,,1234.5678901234,N,12345.678901234,W", 0, ROW_MODEL, 0, 0, KIND_GGA},
		'{"$GPGGA,,12.3.4,N,0.5,E", 0, ROW_MODEL, 0, 0, KIND_GGA},
		'{"$GPGGA,,4530.5,N,12345.6Z,E", 0, ROW_MODEL, 0, 0, KIND_GGA},
		'{"$GPRMC,,A,0000.00001,S,00000.00001,W", 0, ROW_MODEL, 0, 0, KIND_RMC}
	};

	logic clk;
	logic arst_n;

	npp_char_if char_ch ();
	npp_pos_if  fix_ch ();

	nmea_position_parser_core #(
		.FRACTION_DIGITS(FRAC_KEEP),
		.LAT_MAX_CHARS(LAT_MAX_LEN),
		.LON_MAX_CHARS(LON_MAX_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(char_ch),
		.fixes(fix_ch)
	);

	string gga_tag = "$GPGGA";
	string rmc_tag = "$GPRMC";

	logic [PFX_W-1:0] pfx_pos;
	logic             gga_ok;
	logic             rmc_ok;
	logic [FLD_W-1:0] field_no;
	coord_t           lat_acc;
	coord_t           lon_acc;

	fix_t             fixes_due[$];
	logic [CHAR_W-1:0] line_buf[$];
	row_mode_t        line_mode = ROW_MODEL;
	fix_t             typed_fix;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit pressure_go    = 0;
	logic holding;
	int chars_sent = 0;
	int lines_sent = 0;
	int fixes_seen = 0;
	int err_count  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic coord_t coord_feed(input coord_t c, input logic [CHAR_W-1:0] b,
		input int max_len);
		logic [31:0] acc;
		logic        is_dig;
		if (c.len >= max_len)
			return c;
		c.len = c.len + 1'b1;
		is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
		acc = 32'(c.whole) * 32'd10 + 32'(b - CH_ZERO);
		case (c.phase)
			PH_WHOLE: begin
				if (is_dig)
					c.whole = (acc > 32'(WHOLE_MAX)) ? WHOLE_MAX : acc[WHOLE_W-1:0];
				else if (b == CH_DOT)
					c.phase = PH_FRAC;
				else
					c.phase = PH_STOP;
			end
			PH_FRAC: begin
				if (!is_dig) begin
					c.phase = PH_STOP;
				end else if (c.ndig < FRAC_KEEP) begin
					c.frac = c.frac * 10 + (b - CH_ZERO);
					c.ndig = c.ndig + 1'b1;
				end
			end
			default: ;
		endcase
		return c;
	endfunction

	// ddmm.mmmm -> 1e-7 degree, truncated, clamped, then signed by hemisphere
	function automatic logic [LON_W-1:0] coord_units(input coord_t c,
		input logic [CHAR_W-1:0] neg_ch, input longint unsigned limit);
		longint unsigned scale;
		longint unsigned frac_sc;
		longint unsigned whole;
		longint unsigned mag;
		int i;
		scale = 1;
		frac_sc = c.frac;
		whole = c.whole;
		for (i = 0; i < FRAC_KEEP; i++)
			scale = scale * 10;
		for (i = c.ndig; i < FRAC_KEEP; i++)
			frac_sc = frac_sc * 10;
		mag = (whole / 100) * DEG_SCALE
			+ (((whole % 100) * scale + frac_sc) * DEG_SCALE) / (MIN_PER_DEG * scale);
		if (mag > limit)
			mag = limit;
		if (c.hemi == neg_ch)
			mag = -mag;
		return mag[LON_W-1:0];
	endfunction

	task automatic clear_line();
		pfx_pos = '0;
		gga_ok = 1'b1;
		rmc_ok = 1'b1;
		field_no = '0;
		lat_acc = '0;
		lat_acc.hemi = CH_SPACE;
		lon_acc = '0;
		lon_acc.hemi = CH_SPACE;
	endtask

	task automatic parse_char(input logic [CHAR_W-1:0] b);
		fix_t             f;
		logic [LON_W-1:0] lat_bits;
		logic             hit;
		logic [FLD_W-1:0] base;
		if (b == CH_CR)
			return;
		if (b == CH_LF) begin
			hit = (pfx_pos == PFX_LEN) && (gga_ok || rmc_ok) &&
				(lat_acc.len != 0) && (lon_acc.len != 0);
			lat_bits = coord_units(lat_acc, CH_S, LAT_LIMIT);
			f.lat = lat_bits[LAT_W-1:0];
			f.lon = coord_units(lon_acc, CH_W, LON_LIMIT);
			f.kind = rmc_ok;
			case (line_mode)
				ROW_MODEL: begin
					if (hit)
						fixes_due.push_back(f);
				end
				ROW_FIX: fixes_due.push_back(typed_fix);
				default: ;
			endcase
			clear_line();
			return;
		end
		if (pfx_pos < PFX_LEN) begin
			if (b != gga_tag[pfx_pos])
				gga_ok = 1'b0;
			if (b != rmc_tag[pfx_pos])
				rmc_ok = 1'b0;
			pfx_pos = pfx_pos + 1'b1;
		end
		if (b == CH_COMMA) begin
			if (field_no != FLD_MAX)
				field_no = field_no + 1'b1;
			return;
		end
		base = rmc_ok ? LAT_FLD_RMC : LAT_FLD_GGA;
		if (field_no == base)
			lat_acc = coord_feed(lat_acc, b, LAT_MAX_LEN);
		else if (field_no == base + 3'd1)
			lat_acc.hemi = b;
		else if (field_no == base + 3'd2)
			lon_acc = coord_feed(lon_acc, b, LON_MAX_LEN);
		else if (field_no == base + 3'd3)
			lon_acc.hemi = b;
	endtask

	function automatic logic [CHAR_W-1:0] rand_char(input bit no_comma);
		logic [CHAR_W-1:0] b;
		do
			b = CHAR_W'($urandom_range(255));
		while (b == CH_LF || (no_comma && b == CH_COMMA));
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit();
		return CH_ZERO + CHAR_W'($urandom_range(9));
	endfunction

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic add_coord(input int whole_len);
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 8)
			return;
		if (r < 16) begin
			repeat ($urandom_range(4, 1)) line_buf.push_back(rand_char(1));
			return;
		end
		if (r < 22) begin
			repeat ($urandom_range(16, 12))
				line_buf.push_back(($urandom_range(9) == 0) ? CH_DOT : rand_digit());
			return;
		end
		n = (r < 40) ? $urandom_range(7) : whole_len;
		repeat (n) line_buf.push_back(rand_digit());
		if ($urandom_range(4) != 0) begin
			line_buf.push_back(CH_DOT);
			repeat ($urandom_range(8)) line_buf.push_back(rand_digit());
		end
		if ($urandom_range(19) == 0)
			line_buf.push_back(rand_char(1));
	endtask

	task automatic add_hemi(input string pair);
		int r;
		r = $urandom_range(99);
		if (r < 75) begin
			line_buf.push_back(pair[$urandom_range(1)]);
		end else if (r < 85) begin
		end else if (r < 93) begin
			line_buf.push_back(pair[$urandom_range(1)]);
			line_buf.push_back(pair[$urandom_range(1)]);
		end else begin
			line_buf.push_back(rand_char(1));
		end
	endtask

	// mostly well-formed sentences; some with a flipped prefix bit or cut short; some noise
	task automatic build_random_line();
		int r;
		int cut;
		bit rmc;
		r = $urandom_range(99);
		rmc = 1'($urandom_range(1));
		line_buf.delete();
		if (r >= 85) begin
			repeat ($urandom_range(24)) line_buf.push_back(rand_char(0));
			return;
		end
		push_text(rmc ? "$GPRMC," : "$GPGGA,");
		repeat ($urandom_range(6)) line_buf.push_back(rand_digit());
		line_buf.push_back(CH_COMMA);
		if (rmc)
			push_text($urandom_range(1) ? "A," : "V,");
		add_coord(4);
		line_buf.push_back(CH_COMMA);
		add_hemi("NS");
		line_buf.push_back(CH_COMMA);
		add_coord(5);
		line_buf.push_back(CH_COMMA);
		add_hemi("EW");
		repeat ($urandom_range(3)) begin
			line_buf.push_back(CH_COMMA);
			repeat ($urandom_range(4)) line_buf.push_back(rand_char(1));
		end
		if (r >= 75 && r < 80) begin
			line_buf[$urandom_range(5)] ^= CHAR_W'(1 << $urandom_range(7));
		end else if (r >= 80) begin
			cut = $urandom_range(line_buf.size() - 1);
			while (line_buf.size() > cut)
				void'(line_buf.pop_back());
		end
		if ($urandom_range(9) == 0)
			line_buf.insert($urandom_range(line_buf.size()), CH_CR);
		if ($urandom_range(2) == 0)
			line_buf.push_back(CH_CR);
	endtask

	task automatic send_byte(input logic [CHAR_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_in <= b;
		do
			@(posedge clk);
		while (!char_ch.ready);
		parse_char(b);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		int i;
		for (i = 0; i < line_buf.size(); i++)
			send_byte(line_buf[i]);
		send_byte(CH_LF);
		lines_sent++;
	endtask

	always @(negedge clk) begin
		fix_ch.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
	end

	// long output hold-off so the line queue fills and the input stalls
	initial begin
		holding = 1'b0;
		wait (pressure_go);
		@(negedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin : fix_check
		fix_t want;
		if (arst_n && fix_ch.valid && fix_ch.ready) begin
			if (fixes_due.size() == 0) begin
				$error("unexpected fix: latitude %0d longitude %0d kind %0d",
					fix_ch.latitude, fix_ch.longitude, fix_ch.sentence_kind);
				err_count++;
			end else begin
				want = fixes_due.pop_front();
				fixes_seen++;
				if (fix_ch.latitude !== want.lat) begin
					$error("latitude: expected %0d, got %0d", want.lat, fix_ch.latitude);
					err_count++;
				end
				if (fix_ch.longitude !== want.lon) begin
					$error("longitude: expected %0d, got %0d", want.lon, fix_ch.longitude);
					err_count++;
				end
				if (fix_ch.sentence_kind !== want.kind) begin
					$error("sentence_kind: expected %0d, got %0d", want.kind,
						fix_ch.sentence_kind);
					err_count++;
				end
			end
		end
	end

	initial begin
		int ph;
		int waited;
		arst_n = 1'b0;
		char_ch.valid = 1'b0;
		char_ch.char_in = '0;
		clear_line();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			line_mode = dir_rows[i].mode;
			typed_fix.lat = LAT_W'(dir_rows[i].lat);
			typed_fix.lon = LON_W'(dir_rows[i].lon);
			typed_fix.kind = dir_rows[i].kind;
			line_buf.delete();
			push_text(dir_rows[i].text);
			if (dir_rows[i].cr)
				line_buf.push_back(CH_CR);
			send_line();
		end
		line_mode = ROW_MODEL;

		// NUL and high bytes in the time field, carriage return inside the prefix
		line_buf.delete();
		push_text("$GPGGA,");
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		push_text(",0130.5,S,00045,W");
		send_line();
		line_buf.delete();
		push_text("$GP");
		line_buf.push_back(CH_CR);
		push_text("GGA,,0100,N,00100,E");
		send_line();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 33 : 0;
			recv_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 33 : 0;
			repeat (3) begin
				build_random_line();
				send_line();
			end
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		pressure_go = 1;
		repeat (10) begin
			line_buf.delete();
			push_text("$GPGGA,,");
			repeat (2) line_buf.push_back(rand_digit());
			push_text(",S,");
			repeat (3) line_buf.push_back(rand_digit());
			push_text(",W");
			send_line();
		end
		char_ch.valid <= 1'b0;

		waited = 0;
		while ((fixes_due.size() != 0 || holding) && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (fixes_due.size() != 0) begin
			$error("%0d expected fixes never arrived", fixes_due.size());
			err_count++;
		end

		$display("run covered %0d characters in %0d lines: directed, four idle mixes, hold-off",
			chars_sent, lines_sent);
		$display("%0d position fixes checked, %0d mismatches found", fixes_seen, err_count);
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
